@@ hw/rtl/plf_pkg.sv @@
// Shared types, constants and codes of the phase-continuous LED flasher.
`timescale 1ns / 1ps
`default_nettype none

package plf_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Reset values of the configuration registers.
  localparam logic [15:0] PERIOD_MAX_RST = 16'd1000;
  localparam logic [15:0] PERIOD_MIN_RST = 16'd30;
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

  // Full-scale control byte and the smallest legal blink period.
  localparam logic [15:0] CTRL_FULL_SCALE = 16'd255;
  localparam logic [15:0] PERIOD_FLOOR    = 16'd2;

  // Division by the full-scale byte as a multiply by ceil(2^32 / 255) and a shift by 32.
  // The quotient is exact for every dividend below 2^32 / 254, which covers 255 * 65535.
  localparam logic [24:0] CTRL_RECIP       = 25'd16843010;
  localparam int unsigned CTRL_RECIP_SHIFT = 32;

  // Width of the phase arithmetic and steps of the radix-2 divider.
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned DIV_STEPS = ACC_W;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [1:0]  REG_PERIOD_MAX = 2'd0;
  localparam logic [1:0]  REG_PERIOD_MIN = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT    = 2'd2;

  // Result stream: led_on, cur_period, padded to whole bytes.
  localparam int unsigned M_FIELDS_W = 17;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    DIV_SEL_PHASE,
    DIV_SEL_LED
  } plf_div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PERIOD,
    ST_CHECK,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_PHASE_GO,
    ST_PHASE_WAIT,
    ST_LED_GO,
    ST_LED_WAIT,
    ST_DONE
  } plf_state_e;

  typedef struct packed {
    logic         load;
    logic         scale_calc;
    logic         div_start;
    plf_div_sel_e div_sel;
    logic         period_calc;
    logic         mac_clear;
    logic         mac_mul;
    logic         mac_acc;
    logic         phase_upd;
    logic         out_load;
  } plf_cmd_t;

  typedef struct packed {
    logic cmd;
    logic div_busy;
    logic period_changed;
    logic mac_last;
    logic out_busy;
  } plf_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/plf_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module plf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire plf_pkg::plf_sts_t sts_i,
  output plf_pkg::plf_cmd_t     ctl_o
);

  plf_pkg::plf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ctl_o         = '0;
    ctl_o.div_sel = plf_pkg::DIV_SEL_LED;
    s_ready_o     = 1'b0;
    unique case (state_q)
      plf_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = plf_pkg::ST_DECODE;
        end
      end
      plf_pkg::ST_DECODE: begin
        if (sts_i.cmd) begin
          ctl_o.scale_calc = 1'b1;
          state_d          = plf_pkg::ST_PERIOD;
        end else begin
          state_d = plf_pkg::ST_LED_GO;
        end
      end
      plf_pkg::ST_PERIOD: begin
        ctl_o.period_calc = 1'b1;
        state_d           = plf_pkg::ST_CHECK;
      end
      plf_pkg::ST_CHECK: begin
        if (sts_i.period_changed) begin
          ctl_o.mac_clear = 1'b1;
          state_d         = plf_pkg::ST_MAC_MUL;
        end else begin
          state_d = plf_pkg::ST_LED_GO;
        end
      end
      plf_pkg::ST_MAC_MUL: begin
        ctl_o.mac_mul = 1'b1;
        state_d       = plf_pkg::ST_MAC_ACC;
      end
      plf_pkg::ST_MAC_ACC: begin
        ctl_o.mac_acc = 1'b1;
        if (sts_i.mac_last) begin
          state_d = plf_pkg::ST_PHASE_GO;
        end else begin
          state_d = plf_pkg::ST_MAC_MUL;
        end
      end
      // The last partial product has been added, so the numerator is complete here.
      plf_pkg::ST_PHASE_GO: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_sel   = plf_pkg::DIV_SEL_PHASE;
        state_d         = plf_pkg::ST_PHASE_WAIT;
      end
      plf_pkg::ST_PHASE_WAIT: begin
        if (!sts_i.div_busy) begin
          ctl_o.phase_upd = 1'b1;
          state_d         = plf_pkg::ST_LED_GO;
        end
      end
      plf_pkg::ST_LED_GO: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_sel   = plf_pkg::DIV_SEL_LED;
        state_d         = plf_pkg::ST_LED_WAIT;
      end
      plf_pkg::ST_LED_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = plf_pkg::ST_DONE;
        end
      end
      plf_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = plf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/plf_dp.sv @@
// Datapath: item registers, phase state, shared divider, multiply-accumulate and result register.
`timescale 1ns / 1ps
`default_nettype none

module plf_dp #(
  parameter int unsigned TIME_WIDTH = plf_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_cmd_i,
  input  wire logic [TIME_WIDTH-1:0] time_i,
  input  wire logic [7:0]            ctrl_value_i,
  input  wire logic [15:0]           period_max_i,
  input  wire logic [15:0]           period_min_i,
  input  wire logic [15:0]           timeout_i,
  input  wire plf_pkg::plf_cmd_t     ctl_i,
  output plf_pkg::plf_sts_t          sts_o,
  input  wire logic                  m_ready_i,
  output logic                       m_valid_o,
  output logic                       led_on_o,
  output logic [15:0]                cur_period_o
);

  localparam int unsigned AW  = plf_pkg::ACC_W;
  localparam int unsigned CNT_W = $clog2(plf_pkg::DIV_STEPS);

  // Item registers.
  logic                  in_cmd_q;
  logic [TIME_WIDTH-1:0] t_q;
  logic [23:0]           scale_mag_q;
  logic                  scale_neg_q;
  logic signed [17:0]    scaled_q;

  // Persistent state.
  logic [AW-1:0]         phase_q;
  logic [15:0]           blink_q;
  logic [TIME_WIDTH-1:0] last_q;
  logic                  seen_q;
  logic [15:0]           newp_q;

  // Divider.
  logic             div_busy_q;
  logic [CNT_W-1:0] div_cnt_q;
  logic [AW-1:0]    quo_q;
  logic [15:0]      rem_q;
  logic [15:0]      den_q;
  logic             neg_q;

  // Multiply-accumulate.
  logic [2:0]         step_q;
  logic signed [33:0] prod_q;
  logic [AW-1:0]      acc_q;

  // Result register.
  logic        m_valid_q;
  logic        led_q;
  logic [15:0] per_q;

  // Magnitude and sign of ctrl_value * (period_min - period_max).
  logic        span_neg;
  logic [15:0] span_mag;
  logic [23:0] scale_mag;

  assign span_neg  = period_min_i < period_max_i;
  assign span_mag  = span_neg ? (period_max_i - period_min_i) : (period_min_i - period_max_i);
  assign scale_mag = 24'(ctrl_value_i) * 24'(span_mag);

  // Truncating division of the scaled magnitude by the full-scale byte.
  logic [47:0] recip_prod;
  logic [15:0] scale_quo;

  assign recip_prod = 48'(scale_mag_q) * 48'(plf_pkg::CTRL_RECIP);
  assign scale_quo  = recip_prod[plf_pkg::CTRL_RECIP_SHIFT +: 16];

  logic [AW-1:0] t64;
  assign t64 = AW'(t_q);

  // Divider operand selection.
  logic [AW-1:0] div_num;
  logic [15:0]   div_den;

  always_comb begin
    unique case (ctl_i.div_sel)
      plf_pkg::DIV_SEL_PHASE: begin
        div_num = acc_q;
        div_den = blink_q;
      end
      default: begin
        div_num = t64 - phase_q;
        div_den = blink_q;
      end
    endcase
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  logic [16:0] div_sh, div_diff;
  logic        div_ge;
  logic [AW-1:0] quo_signed;

  assign div_sh     = {rem_q, quo_q[AW-1]};
  assign div_diff   = div_sh - {1'b0, den_q};
  assign div_ge     = div_sh >= {1'b0, den_q};
  assign quo_signed = neg_q ? (~quo_q + AW'(1)) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (ctl_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + CNT_W'(1);
      if (div_cnt_q == CNT_W'(plf_pkg::DIV_STEPS - 1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      neg_q <= div_num[AW-1];
      quo_q <= div_num[AW-1] ? (~div_num + AW'(1)) : div_num;
      rem_q <= '0;
      den_q <= div_den;
    end else if (div_busy_q) begin
      quo_q <= {quo_q[AW-2:0], div_ge};
      rem_q <= div_ge ? div_diff[15:0] : div_sh[15:0];
    end
  end

  // New period from the signed scaled value, floored at two.
  logic signed [17:0] np;
  logic [15:0]        np_clamped;

  assign np         = $signed({2'b0, period_max_i}) + scaled_q;
  assign np_clamped = (np < $signed({2'b0, plf_pkg::PERIOD_FLOOR})) ?
                      plf_pkg::PERIOD_FLOOR : np[15:0];

  // Numerator t*(old-new) + new*phase, built from 16-bit slices of t and phase.
  logic [15:0]        mac_a;
  logic signed [16:0] mac_b;
  logic [AW-1:0]      prod_ext;

  assign mac_a    = step_q[2] ? phase_q[{step_q[1:0], 4'b0} +: 16]
                              : t64[{step_q[1:0], 4'b0} +: 16];
  assign mac_b    = step_q[2] ? $signed({1'b0, newp_q})
                              : $signed({1'b0, blink_q}) - $signed({1'b0, newp_q});
  assign prod_ext = {{(AW-34){prod_q[33]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      in_cmd_q    <= in_cmd_i;
      t_q         <= time_i;
      scale_mag_q <= scale_mag;
      scale_neg_q <= span_neg;
    end
    if (ctl_i.scale_calc) begin
      scaled_q <= scale_neg_q ? -$signed({2'b0, scale_quo}) : $signed({2'b0, scale_quo});
    end
    if (ctl_i.period_calc) begin
      newp_q <= np_clamped;
    end
    if (ctl_i.mac_clear) begin
      acc_q  <= '0;
      step_q <= '0;
    end else if (ctl_i.mac_acc) begin
      acc_q  <= acc_q + (prod_ext << {step_q[1:0], 4'b0});
      step_q <= step_q + 3'd1;
    end
    if (ctl_i.mac_mul) begin
      prod_q <= $signed({1'b0, mac_a}) * mac_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      blink_q <= plf_pkg::PERIOD_MAX_RST;
      last_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      if (ctl_i.period_calc) begin
        last_q <= t_q;
        seen_q <= 1'b1;
      end
      if (ctl_i.phase_upd) begin
        phase_q <= quo_signed;
        blink_q <= newp_q;
      end
    end
  end

  // LED decision from the remainder of (t - phase) by the current period, given a frame within the timeout.
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  recent, led_d;

  assign elapsed = t_q - last_q;
  assign recent  = elapsed < TIME_WIDTH'(timeout_i);
  assign led_d   = seen_q && recent && (neg_q || (rem_q < (blink_q >> 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      led_q <= led_d;
      per_q <= blink_q;
    end
  end

  assign m_valid_o    = m_valid_q;
  assign led_on_o     = led_q;
  assign cur_period_o = per_q;

  assign sts_o.cmd            = in_cmd_q;
  assign sts_o.div_busy       = div_busy_q;
  assign sts_o.period_changed = newp_q != blink_q;
  assign sts_o.mac_last       = step_q == 3'd7;
  assign sts_o.out_busy       = m_valid_q && !m_ready_i;

`ifndef NO_ASSERTIONS
  a_blink_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q >= plf_pkg::PERIOD_FLOOR)
    else $error("blink period fell below the floor");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_phase_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.phase_upd |-> !div_busy_q)
    else $error("phase written while divider busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> !(m_valid_q && !m_ready_i))
    else $error("result register overwritten before transfer");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/phase_continuous_led_flasher_top.sv @@
// Top level of the phase-continuous LED flasher: ports, configuration registers and packing.
//
//  Channel      Direction  Transfer when              Content
//  s_axis       in         tvalid & tready            tuser: cmd; tdata: time_ms, ctrl_value
//  m_axis       out        tvalid & tready            tdata: led_on, cur_period
//  APB          in/out     psel & penable & pwrite    period_max, period_min, timeout_ms
//
// The shared 64-step radix-2 divider does most of the work of an item: one division for the
// LED, one more for the phase when a frame changes the period. The 16-bit multiply-accumulate
// builds the phase numerator, and the byte scaling is a reciprocal multiply.
// One item is in work at a time; the next is taken while a result waits on m_axis.
// A stalled m_axis holds the block in its final state until the result is taken.
// Reset clears the phase, the frame flag and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module phase_continuous_led_flasher_top #(
  parameter int unsigned TIME_WIDTH = plf_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input item transfer.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: time_ms[TIME_WIDTH-1:0], ctrl_value[7:0], zero pad.
  input  wire logic [((TIME_WIDTH+8+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: cmd.
  input  wire logic                             s_axis_tuser_i,
  // Result transfer.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata: led_on, cur_period[15:0], zero pad.
  output logic [plf_pkg::M_TDATA_W-1:0]          m_axis_tdata_o,
  // Configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [plf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [plf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [plf_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                  pready
);

  logic [15:0] period_max_q, period_min_q, timeout_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_max_q <= plf_pkg::PERIOD_MAX_RST;
      period_min_q <= plf_pkg::PERIOD_MIN_RST;
      timeout_q    <= plf_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        plf_pkg::REG_PERIOD_MAX: period_max_q <= pwdata[15:0];
        plf_pkg::REG_PERIOD_MIN: period_min_q <= pwdata[15:0];
        plf_pkg::REG_TIMEOUT:    timeout_q    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      plf_pkg::REG_PERIOD_MAX: prdata = plf_pkg::CFG_DATA_W'(period_max_q);
      plf_pkg::REG_PERIOD_MIN: prdata = plf_pkg::CFG_DATA_W'(period_min_q);
      plf_pkg::REG_TIMEOUT:    prdata = plf_pkg::CFG_DATA_W'(timeout_q);
      default:                 prdata = '0;
    endcase
  end

  plf_pkg::plf_cmd_t ctl;
  plf_pkg::plf_sts_t sts;
  logic              led_on;
  logic [15:0]       cur_period;

  plf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  plf_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser_i),
    .time_i       (s_axis_tdata_i[TIME_WIDTH-1:0]),
    .ctrl_value_i (s_axis_tdata_i[TIME_WIDTH +: 8]),
    .period_max_i (period_max_q),
    .period_min_i (period_min_q),
    .timeout_i    (timeout_q),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .m_ready_i    (m_axis_tready_i),
    .m_valid_o    (m_axis_tvalid_o),
    .led_on_o     (led_on),
    .cur_period_o (cur_period)
  );

  assign m_axis_tdata_o = {{(plf_pkg::M_TDATA_W - plf_pkg::M_FIELDS_W){1'b0}}, cur_period, led_on};

endmodule

`default_nettype wire
